// ===== hdl/plle_pkg.sv =====
// Shared constants, types and codes for the positional linked list engine.
package plle_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int NODE_W      = $clog2(CAPACITY);
  // Counts, positions and links (with the null marker) share one width.
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KIND_W      = 4;
  localparam int STATUS_W    = 2;

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  localparam cnt_t NULL_LINK = cnt_t'(CAPACITY);
  localparam cnt_t FULL_CNT  = cnt_t'(CAPACITY);

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT  = 4'd0,
    K_INS_BACK   = 4'd1,
    K_INS_AT     = 4'd2,
    K_READ_FRONT = 4'd3,
    K_READ_BACK  = 4'd4,
    K_READ_AT    = 4'd5,
    K_RM_FRONT   = 4'd6,
    K_RM_BACK    = 4'd7,
    K_RM_AT      = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_READ,
    OP_REMOVE
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_INS_A,
    S_INS_B,
    S_APPLY,
    S_RESP
  } state_t;

endpackage

// ===== hdl/plle_req_if.sv =====
// Request channel interface: valid/ready plus the request fields.
interface plle_req_if;
  logic                            valid;
  logic                            ready;
  logic [plle_pkg::KIND_W-1:0]     kind;
  logic [plle_pkg::CNT_W-1:0]      position;
  logic [plle_pkg::HANDLE_BITS-1:0] payload;

  modport source (output valid, kind, position, payload, input ready);
  modport sink   (input valid, kind, position, payload, output ready);
endinterface

// ===== hdl/plle_rsp_if.sv =====
// Result channel interface: valid/ready plus the result fields.
interface plle_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [plle_pkg::STATUS_W-1:0]    status;
  logic [plle_pkg::HANDLE_BITS-1:0] handle_out;
  logic [plle_pkg::CNT_W-1:0]       entry_count;

  modport source (output valid, status, handle_out, entry_count, input ready);
  modport sink   (input valid, status, handle_out, entry_count, output ready);
endinterface

// ===== hdl/plle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/positional_linked_list_engine.sv =====
// Top level: doubly linked list of handles over a node pool, run by a small sequencer.
//
//  channel   dir  handshake        fields
//  in_chan   in   valid/ready      kind, position, payload
//  out_chan  out  valid/ready      status, handle_out, entry_count
//
// Steps: a rejected request goes from accept to result. Front/back read or remove:
// fetch, apply. Front/back insert: fetch, write the new node, link its neighbours.
// Positional requests first walk from the head, up to CAPACITY-1 link hops, via fwd RAM.
// Reset clears the control registers only; the node RAMs need no clearing
// because fresh nodes come from a fill counter and released ones from a stack.
// The result is held until out_chan takes it; no request is taken meanwhile.
module positional_linked_list_engine import plle_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  plle_req_if.sink      in_chan,
  plle_rsp_if.source    out_chan
);

  // ---------------------------------------------------------------------
  // Control and list registers
  // ---------------------------------------------------------------------
  state_t  state_r, state_nxt;
  op_t     op_r;
  handle_t payload_r;
  cnt_t    node_r;        // target node: prev for inserts, victim for reads/removes
  cnt_t    nxt_r;         // successor of the new node during insert
  node_t   new_r;         // node taken for insert
  cnt_t    steps_r;       // link hops left in the walk
  cnt_t    head_r, tail_r, count_r;
  cnt_t    fresh_r;       // distinct nodes ever handed out from the pool
  cnt_t    rel_r;         // depth of the released-node stack
  status_t out_status_r;
  handle_t out_handle_r;

  // RAM ports
  logic    hnd_we, fwd_we, bwd_we, free_we;
  node_t   hnd_waddr, fwd_waddr, bwd_waddr, free_waddr;
  handle_t hnd_wdata, hnd_rd;
  cnt_t    fwd_wdata, bwd_wdata, fwd_rd, bwd_rd;
  node_t   free_wdata, free_rd;
  node_t   hnd_raddr, fwd_raddr, bwd_raddr, free_raddr;

  logic    accept;
  assign accept          = in_chan.valid && in_chan.ready;
  assign in_chan.ready   = (state_r == S_IDLE);
  assign out_chan.valid  = (state_r == S_RESP);
  assign out_chan.status      = out_status_r;
  assign out_chan.handle_out  = out_handle_r;
  assign out_chan.entry_count = count_r;

  // ---------------------------------------------------------------------
  // Request decode: checks errors and picks the starting node
  // ---------------------------------------------------------------------
  logic    dec_err, dec_walk, dec_idx_use;
  status_t dec_status;
  op_t     dec_op;
  cnt_t    dec_node, dec_idx;
  logic    full, empty;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  always_comb begin
    dec_err     = 1'b0;
    dec_status  = ST_OK;
    dec_op      = OP_READ;
    dec_node    = head_r;
    dec_idx     = '0;
    dec_idx_use = 1'b0;
    case (kind_t'(in_chan.kind))
      K_INS_FRONT: begin
        dec_op     = OP_INS;
        dec_err    = full;
        dec_status = ST_FULL;
        dec_node   = NULL_LINK;
      end
      K_INS_BACK: begin
        dec_op     = OP_INS;
        dec_err    = full;
        dec_status = ST_FULL;
        dec_node   = tail_r;
      end
      K_INS_AT: begin
        dec_op = OP_INS;
        if (in_chan.position > count_r) begin
          dec_err    = 1'b1;
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_err    = 1'b1;
          dec_status = ST_FULL;
        end else if (in_chan.position == '0) begin
          dec_node = NULL_LINK;
        end else if (in_chan.position == count_r) begin
          dec_node = tail_r;
        end else begin
          // link after the node just before the position
          dec_idx_use = 1'b1;
          dec_idx     = in_chan.position - cnt_t'(1);
        end
      end
      K_READ_FRONT, K_RM_FRONT: begin
        dec_op     = (kind_t'(in_chan.kind) == K_RM_FRONT) ? OP_REMOVE : OP_READ;
        dec_err    = empty;
        dec_status = ST_EMPTY;
        dec_node   = head_r;
      end
      K_READ_BACK, K_RM_BACK: begin
        dec_op     = (kind_t'(in_chan.kind) == K_RM_BACK) ? OP_REMOVE : OP_READ;
        dec_err    = empty;
        dec_status = ST_EMPTY;
        dec_node   = tail_r;
      end
      K_READ_AT, K_RM_AT: begin
        dec_op = (kind_t'(in_chan.kind) == K_RM_AT) ? OP_REMOVE : OP_READ;
        if (in_chan.position >= count_r) begin
          dec_err    = 1'b1;
          dec_status = ST_BADPOS;
        end else begin
          dec_idx_use = 1'b1;
          dec_idx     = in_chan.position;
        end
      end
      default: begin
        dec_err    = 1'b1;
        dec_status = ST_BADPOS;
      end
    endcase
    // index zero is the head itself; anything further needs a walk
    dec_walk = dec_idx_use && (dec_idx != '0);
    if (dec_idx_use) begin
      dec_node = head_r;
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dec_err)       state_nxt = S_RESP;
          else if (dec_walk) state_nxt = S_WALK;
          else               state_nxt = S_FETCH;
        end
      end
      S_WALK:  if (steps_r == cnt_t'(1)) state_nxt = S_FETCH;
      S_FETCH: state_nxt = (op_r == OP_INS) ? S_INS_A : S_APPLY;
      S_INS_A: state_nxt = S_INS_B;
      S_INS_B: state_nxt = S_RESP;
      S_APPLY: state_nxt = S_RESP;
      S_RESP:  if (out_chan.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // RAM control
  // ---------------------------------------------------------------------
  node_t alloc_node;
  cnt_t  ins_next;
  logic  rm_prev_ok, rm_next_ok;

  // released nodes are reused first, else the next never-used node
  assign alloc_node = (rel_r != '0) ? free_rd : fresh_r[NODE_W-1:0];
  assign ins_next   = (node_r != NULL_LINK) ? fwd_rd : head_r;
  assign rm_prev_ok = (bwd_rd != NULL_LINK);
  assign rm_next_ok = (fwd_rd != NULL_LINK);

  always_comb begin
    hnd_we     = 1'b0;
    fwd_we     = 1'b0;
    bwd_we     = 1'b0;
    free_we    = 1'b0;
    hnd_waddr  = alloc_node;
    hnd_wdata  = payload_r;
    fwd_waddr  = alloc_node;
    fwd_wdata  = ins_next;
    bwd_waddr  = alloc_node;
    bwd_wdata  = node_r;
    free_waddr = rel_r[NODE_W-1:0];
    free_wdata = node_r[NODE_W-1:0];
    fwd_raddr  = node_r[NODE_W-1:0];
    bwd_raddr  = node_r[NODE_W-1:0];
    hnd_raddr  = node_r[NODE_W-1:0];
    free_raddr = node_t'(rel_r - cnt_t'(1));
    case (state_r)
      S_IDLE: fwd_raddr = head_r[NODE_W-1:0];   // first hop of a walk
      S_WALK: fwd_raddr = fwd_rd[NODE_W-1:0];   // one hop per cycle
      S_INS_A: begin
        hnd_we = 1'b1;
        fwd_we = 1'b1;
        bwd_we = 1'b1;
      end
      S_INS_B: begin
        fwd_we    = (node_r != NULL_LINK);
        fwd_waddr = node_r[NODE_W-1:0];
        fwd_wdata = cnt_t'(new_r);
        bwd_we    = (nxt_r != NULL_LINK);
        bwd_waddr = nxt_r[NODE_W-1:0];
        bwd_wdata = cnt_t'(new_r);
      end
      S_APPLY: begin
        if (op_r == OP_REMOVE) begin
          fwd_we    = rm_prev_ok;
          fwd_waddr = bwd_rd[NODE_W-1:0];
          fwd_wdata = fwd_rd;
          bwd_we    = rm_next_ok;
          bwd_waddr = fwd_rd[NODE_W-1:0];
          bwd_wdata = bwd_rd;
          free_we   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  plle_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_hnd_ram (
    .clk(clk), .we(hnd_we), .waddr(hnd_waddr), .wdata(hnd_wdata),
    .raddr(hnd_raddr), .rdata(hnd_rd)
  );

  plle_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(fwd_raddr), .rdata(fwd_rd)
  );

  plle_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
    .raddr(bwd_raddr), .rdata(bwd_rd)
  );

  plle_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rd)
  );

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NULL_LINK;
      tail_r  <= NULL_LINK;
      count_r <= '0;
      fresh_r <= '0;
      rel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= dec_op;
            payload_r    <= in_chan.payload;
            node_r       <= dec_node;
            steps_r      <= dec_idx;
            out_status_r <= dec_status;
            out_handle_r <= '0;
          end
        end
        S_WALK: begin
          steps_r <= steps_r - cnt_t'(1);
          if (steps_r == cnt_t'(1)) begin
            node_r <= fwd_rd;
          end
        end
        S_INS_A: begin
          new_r <= alloc_node;
          nxt_r <= ins_next;
        end
        S_INS_B: begin
          if (node_r == NULL_LINK) head_r <= cnt_t'(new_r);
          if (nxt_r == NULL_LINK)  tail_r <= cnt_t'(new_r);
          count_r <= count_r + cnt_t'(1);
          if (rel_r != '0) rel_r   <= rel_r - cnt_t'(1);
          else             fresh_r <= fresh_r + cnt_t'(1);
          out_status_r <= ST_OK;
          out_handle_r <= '0;
        end
        S_APPLY: begin
          out_status_r <= ST_OK;
          out_handle_r <= hnd_rd;
          if (op_r == OP_REMOVE) begin
            if (!rm_prev_ok) head_r <= fwd_rd;
            if (!rm_next_ok) tail_r <= bwd_rd;
            count_r <= count_r - cnt_t'(1);
            rel_r   <= rel_r + cnt_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // live entries always equal nodes handed out minus nodes returned
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_r - rel_r) == count_r)
    else $error("pool accounting out of step with entry count");

  // head and tail are null exactly when the list is empty
  a_ends_null: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) == (head_r == NULL_LINK)) && ((count_r == '0) == (tail_r == NULL_LINK)))
    else $error("list ends disagree with entry count");

  // a walk only follows links of nodes inside the list
  a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (fwd_rd != NULL_LINK))
    else $error("walk ran off the end of the list");

  // an accepted insert leaves one more entry once its result is offered
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_B) |=> (count_r == $past(count_r) + cnt_t'(1)))
    else $error("insert did not grow the list");

endmodule
